FILE: hw/rtl/dfi_pkg.sv
// Shared constants, power-of-ten tables and helper functions for the decimal float encoder.
package dfi_pkg;

  localparam int DFI_POWER_ENTRIES = 21;
  localparam int TABLE_DEPTH       = 21;
  localparam int FMUL_LAT          = 5;
  localparam int FADD_LAT          = 6;

  localparam logic [63:0] QNAN    = 64'h7FF8_0000_0000_0000;
  localparam logic [10:0] EXP_MAX = 11'h7FF;

  typedef enum logic [1:0] {
    REG_POWER_UP   = 2'd0,
    REG_POWER_DOWN = 2'd1,
    REG_MAX_ERROR  = 2'd2
  } cfg_reg_t;

  typedef logic [63:0] pow_tab_t [TABLE_DEPTH];

  function automatic logic [6:0] lzc64(logic [63:0] x);
    logic [6:0] n;
    logic       found;
    n     = 7'd64;
    found = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (!found && x[i]) begin
        n     = 7'(63 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [63:0] pow10_bits(int k);
    logic [127:0] d;
    int           l;
    d = 128'd1;
    for (int i = 0; i < k; i++) begin
      d = (d << 3) + (d << 1);
    end
    l = 0;
    for (int i = 0; i < 128; i++) begin
      if (d[i]) begin
        l = i;
      end
    end
    d = (l > 52) ? (d >> (l - 52)) : (d << (52 - l));
    return {1'b0, 11'(1023 + l), d[51:0]};
  endfunction

  function automatic logic [63:0] pow10_neg_bits(int k);
    logic [127:0] d;
    logic [127:0] r;
    logic [53:0]  q;
    logic [52:0]  m;
    logic [11:0]  ex;
    logic         st;
    logic         done;
    logic         bit_v;
    int           n;
    int           e;
    d = 128'd1;
    for (int i = 0; i < k; i++) begin
      d = (d << 3) + (d << 1);
    end
    r     = 128'd1;
    q     = '0;
    n     = 0;
    e     = 0;
    st    = 1'b0;
    done  = 1'b0;
    bit_v = 1'b0;
    for (int i = 0; i < 200; i++) begin
      if (!done) begin
        if (i > 0) begin
          r = r << 1;
        end
        bit_v = (r >= d);
        if (bit_v) begin
          r = r - d;
        end
        if (n > 0 || bit_v) begin
          if (n == 0) begin
            e = i;
          end
          q = {q[52:0], bit_v};
          n = n + 1;
          if (n == 54) begin
            done = 1'b1;
            st   = (r != '0);
          end
        end
      end
    end
    m  = q[53:1] + 53'((q[0] && (st || q[1])) ? 1 : 0);
    ex = 12'(1023 - e);
    return {1'b0, ex[10:0], m[51:0]};
  endfunction

  function automatic pow_tab_t pos_table();
    pow_tab_t t;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      t[k] = pow10_bits(k);
    end
    return t;
  endfunction

  function automatic pow_tab_t neg_table();
    pow_tab_t t;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      t[k] = pow10_neg_bits(k);
    end
    return t;
  endfunction

  localparam pow_tab_t POS_POW = pos_table();
  localparam pow_tab_t NEG_POW = neg_table();

endpackage

FILE: hw/rtl/dfi_if.sv
// Valid/ready channel interfaces for input, result and configuration words.
interface dfi_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value_bits;
  modport source (output valid, output value_bits, input ready);
  modport sink (input valid, input value_bits, output ready);
endinterface

interface dfi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] encoded_value;
  logic               exception_flag;
  modport source (output valid, output encoded_value, output exception_flag, input ready);
  modport sink (input valid, input encoded_value, input exception_flag, output ready);
endinterface

interface dfi_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/dfi_fmul.sv
// Five-stage pipelined IEEE-754 double multiplier, round to nearest even.
module dfi_fmul import dfi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        out_valid,
  output logic [63:0] y
);

  typedef struct packed {
    logic               nan;
    logic               inf;
    logic               zero;
    logic               sgn;
    logic [52:0]        man;
    logic signed [12:0] exp;
  } unp_t;

  typedef struct packed {
    logic nan;
    logic inf;
    logic zero;
    logic sgn;
  } spc_t;

  function automatic unp_t unpack(logic [63:0] x);
    unp_t        u;
    logic [52:0] m;
    logic [6:0]  lz;
    logic [10:0] ef;
    m      = {x[62:52] != 11'd0, x[51:0]};
    lz     = lzc64({m, 11'b0});
    ef     = (x[62:52] == 11'd0) ? 11'd1 : x[62:52];
    u.sgn  = x[63];
    u.nan  = (x[62:52] == EXP_MAX) && (x[51:0] != '0);
    u.inf  = (x[62:52] == EXP_MAX) && (x[51:0] == '0);
    u.zero = (x[62:0] == '0);
    u.man  = m << lz;
    u.exp  = $signed({2'b00, ef}) - 13'sd1023 - $signed({6'b0, lz});
    return u;
  endfunction

  unp_t ua;
  unp_t ub;
  spc_t spc_a;

  logic               va_r;
  spc_t               sa_r;
  logic [52:0]        ma_r;
  logic [52:0]        mb_r;
  logic signed [12:0] ea_r;

  logic               vb_r;
  spc_t               sb_r;
  logic signed [12:0] eb_r;
  logic [53:0]        hh_r;
  logic [52:0]        hl_r;
  logic [52:0]        lh_r;
  logic [51:0]        ll_r;

  logic               vc_r;
  spc_t               sc_r;
  logic signed [12:0] ec_r;
  logic [105:0]       p_r;

  logic               vd_r;
  spc_t               sd_r;
  logic [52:0]        md_r;
  logic               gd_r;
  logic               std_r;
  logic [10:0]        fd_r;
  logic               ovd_r;

  logic               ve_r;
  logic [63:0]        ye_r;

  logic [105:0]       x_d;
  logic [105:0]       y_d;
  logic [105:0]       mask_d;
  logic signed [12:0] eb_d;
  logic signed [12:0] shw_d;
  logic [6:0]         sh_d;
  logic               so_d;

  logic               up_e;
  logic [62:0]        body_e;
  logic [63:0]        y_nxt;

  always_comb begin
    ua         = unpack(a);
    ub         = unpack(b);
    spc_a.nan  = ua.nan | ub.nan | (ua.inf & ub.zero) | (ub.inf & ua.zero);
    spc_a.inf  = (ua.inf | ub.inf) & ~spc_a.nan;
    spc_a.zero = (ua.zero | ub.zero) & ~spc_a.nan & ~spc_a.inf;
    spc_a.sgn  = ua.sgn ^ ub.sgn;
  end

  always_comb begin
    x_d    = p_r[105] ? p_r : (p_r << 1);
    eb_d   = ec_r + (p_r[105] ? 13'sd1 : 13'sd0) + 13'sd1023;
    shw_d  = 13'sd1 - eb_d;
    if (eb_d >= 13'sd1) begin
      sh_d = 7'd0;
    end else if (shw_d > 13'sd127) begin
      sh_d = 7'd127;
    end else begin
      sh_d = shw_d[6:0];
    end
    mask_d = (106'd1 << sh_d) - 106'd1;
    so_d   = |(x_d & mask_d);
    y_d    = x_d >> sh_d;
  end

  always_comb begin
    up_e   = gd_r & (std_r | md_r[0]);
    body_e = {fd_r, md_r[51:0]} + 63'(up_e);
    if (sd_r.nan) begin
      y_nxt = QNAN;
    end else if (sd_r.inf || ovd_r) begin
      y_nxt = {sd_r.sgn, EXP_MAX, 52'd0};
    end else if (sd_r.zero) begin
      y_nxt = {sd_r.sgn, 63'd0};
    end else begin
      y_nxt = {sd_r.sgn, body_e};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_r  <= spc_a;
      ma_r  <= ua.man;
      mb_r  <= ub.man;
      ea_r  <= ua.exp + ub.exp;

      sb_r  <= sa_r;
      eb_r  <= ea_r;
      hh_r  <= ma_r[52:26] * mb_r[52:26];
      hl_r  <= ma_r[52:26] * mb_r[25:0];
      lh_r  <= ma_r[25:0] * mb_r[52:26];
      ll_r  <= ma_r[25:0] * mb_r[25:0];

      sc_r  <= sb_r;
      ec_r  <= eb_r;
      p_r   <= ({52'd0, hh_r} << 52) + ({53'd0, hl_r} << 26) + ({53'd0, lh_r} << 26)
               + {54'd0, ll_r};

      sd_r  <= sc_r;
      md_r  <= y_d[105:53];
      gd_r  <= y_d[52];
      std_r <= (|y_d[51:0]) | so_d;
      fd_r  <= (eb_d >= 13'sd1) ? eb_d[10:0] : 11'd0;
      ovd_r <= (eb_d >= 13'sd2047);

      ye_r  <= y_nxt;
    end
  end

  assign out_valid = ve_r;
  assign y         = ye_r;

endmodule

FILE: hw/rtl/dfi_fadd.sv
// Six-stage pipelined IEEE-754 double subtractor x - y, round to nearest even.
module dfi_fadd import dfi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [63:0] x,
  input  logic [63:0] y,
  output logic        out_valid,
  output logic [63:0] z
);

  typedef struct packed {
    logic nan;
    logic inf;
    logic sgn;
    logic sub;
  } ctl_t;

  logic [63:0] yn;
  logic [63:0] big;
  logic [63:0] sml;
  logic [10:0] ebig;
  logic [10:0] esml;
  logic        nanx;
  logic        nany;
  logic        infx;
  logic        infy;
  ctl_t        ctl_1;

  logic        v1_r;
  ctl_t        c1_r;
  logic [10:0] e1_r;
  logic [52:0] ma1_r;
  logic [52:0] mb1_r;
  logic [10:0] d1_r;

  logic        v2_r;
  ctl_t        c2_r;
  logic [10:0] e2_r;
  logic [55:0] a2_r;
  logic [55:0] b2_r;

  logic        v3_r;
  ctl_t        c3_r;
  logic [10:0] e3_r;
  logic [56:0] s3_r;

  logic        v4_r;
  ctl_t        c4_r;
  logic [10:0] e4_r;
  logic [56:0] s4_r;
  logic [6:0]  lz4_r;

  logic        v5_r;
  ctl_t        c5_r;
  logic [55:0] t5_r;
  logic [11:0] e5_r;
  logic        z5_r;

  logic        v6_r;
  logic [63:0] z6_r;

  logic [5:0]  dd;
  logic [55:0] bsh;
  logic [55:0] bmask;
  logic [10:0] lim;
  logic [5:0]  nsh;
  logic [55:0] t_nxt;
  logic [11:0] e_nxt;
  logic [10:0] fld;
  logic        up6;
  logic [62:0] body6;
  logic [63:0] z_nxt;

  always_comb begin
    yn    = {~y[63], y[62:0]};
    big   = (yn[62:0] > x[62:0]) ? yn : x;
    sml   = (yn[62:0] > x[62:0]) ? x : yn;
    ebig  = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
    esml  = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];
    nanx  = (x[62:52] == EXP_MAX) && (x[51:0] != '0);
    nany  = (y[62:52] == EXP_MAX) && (y[51:0] != '0);
    infx  = (x[62:52] == EXP_MAX) && (x[51:0] == '0);
    infy  = (y[62:52] == EXP_MAX) && (y[51:0] == '0);
    ctl_1.sub = big[63] ^ sml[63];
    ctl_1.sgn = big[63];
    ctl_1.nan = nanx | nany | (infx & infy & ctl_1.sub);
    ctl_1.inf = (infx | infy) & ~ctl_1.nan;
  end

  always_comb begin
    dd    = (d1_r > 11'd63) ? 6'd63 : d1_r[5:0];
    bmask = (56'd1 << dd) - 56'd1;
    bsh   = ({mb1_r, 3'b000} >> dd) | {55'd0, |({mb1_r, 3'b000} & bmask)};
  end

  always_comb begin
    lim = e4_r - 11'd1;
    nsh = ({4'd0, lz4_r} > lim) ? lim[5:0] : lz4_r[5:0];
    if (s4_r[56]) begin
      t_nxt = {s4_r[56:2], s4_r[1] | s4_r[0]};
      e_nxt = {1'b0, e4_r} + 12'd1;
    end else begin
      t_nxt = s4_r[55:0] << nsh;
      e_nxt = {1'b0, e4_r} - {6'd0, nsh};
    end
  end

  always_comb begin
    fld   = t5_r[55] ? e5_r[10:0] : 11'd0;
    up6   = t5_r[2] & (t5_r[1] | t5_r[0] | t5_r[3]);
    body6 = {fld, t5_r[54:3]} + 63'(up6);
    if (c5_r.nan) begin
      z_nxt = QNAN;
    end else if (c5_r.inf || (t5_r[55] && e5_r >= 12'd2047)) begin
      z_nxt = {c5_r.sgn, EXP_MAX, 52'd0};
    end else if (z5_r) begin
      z_nxt = {c5_r.sgn & ~c5_r.sub, 63'd0};
    end else begin
      z_nxt = {c5_r.sgn, body6};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r  <= ctl_1;
      e1_r  <= ebig;
      ma1_r <= {big[62:52] != 11'd0, big[51:0]};
      mb1_r <= {sml[62:52] != 11'd0, sml[51:0]};
      d1_r  <= ebig - esml;

      c2_r  <= c1_r;
      e2_r  <= e1_r;
      a2_r  <= {ma1_r, 3'b000};
      b2_r  <= bsh;

      c3_r  <= c2_r;
      e3_r  <= e2_r;
      s3_r  <= c2_r.sub ? ({1'b0, a2_r} - {1'b0, b2_r}) : ({1'b0, a2_r} + {1'b0, b2_r});

      c4_r  <= c3_r;
      e4_r  <= e3_r;
      s4_r  <= s3_r;
      lz4_r <= lzc64({s3_r[55:0], 8'd0});

      c5_r  <= c4_r;
      t5_r  <= t_nxt;
      e5_r  <= e_nxt;
      z5_r  <= (s4_r == '0);

      z6_r  <= z_nxt;
    end
  end

  assign out_valid = v6_r;
  assign z         = z6_r;

endmodule

FILE: hw/rtl/decimal_float_to_int_encoder.sv
// Top level: decimal scaling of a double to a 32-bit integer with round-trip error check.
// Throughput: one word per cycle; the pipeline holds only when a result waits at the output.
// Stages: two 5-stage multipliers, 3 rounding stages, two 5-stage multipliers,
// a 6-stage subtractor and the output register.
// Reset clears the configuration registers and all valid bits; payload is not reset.
module decimal_float_to_int_encoder import dfi_pkg::*; #(
  parameter int POWER_TABLE_ENTRIES = DFI_POWER_ENTRIES
) (
  input  logic   clk,
  input  logic   rst_n,
  dfi_in_if.sink    in_word,
  dfi_out_if.source out_word,
  dfi_cfg_if.sink   cfg_word
);

  localparam logic [4:0] IDX_MAX = 5'(POWER_TABLE_ENTRIES - 1);
  localparam int         SIDE_LEN = 2 * FMUL_LAT + FADD_LAT;

  typedef struct packed {
    logic [63:0] v;
    logic [31:0] q;
    logic        exc;
  } side_t;

  logic [4:0]  up_r;
  logic [4:0]  dn_r;
  logic [63:0] thr_r;
  logic [4:0]  up_c;
  logic [4:0]  dn_c;

  logic        en;
  logic        out_load;

  logic [63:0] va_dly_r [2*FMUL_LAT];
  side_t       sd_r [SIDE_LEN];

  logic        m0_valid;
  logic [63:0] m0_y;
  logic        m1_valid;
  logic [63:0] m1_y;
  logic        m2_valid;
  logic [63:0] m2_y;
  logic        m3_valid;
  logic [63:0] m3_y;
  logic        add_valid;
  logic [63:0] diff;

  logic        r1_valid_r;
  logic        r1_s_r;
  logic        r1_big_r;
  logic [85:0] r1_f_r;
  logic [63:0] r1_v_r;

  logic        r2_valid_r;
  logic [31:0] r2_q_r;
  logic        r2_exc_r;
  logic [31:0] r2_qmag_r;
  logic        r2_qneg_r;
  logic [63:0] r2_v_r;

  logic        r3_valid_r;
  logic [63:0] r3_dq_r;
  logic [31:0] r3_q_r;
  logic        r3_exc_r;
  logic [63:0] r3_v_r;

  logic        out_valid_r;
  logic [31:0] enc_r;
  logic        exc_r;

  logic [10:0] pe;
  logic        big1;
  logic        small1;
  logic [5:0]  sh1;
  logic [85:0] f1;

  logic [32:0] ip2;
  logic        up2;
  logic [33:0] mag2;
  logic        exc2;
  logic [31:0] qmag2;

  logic [6:0]  lz3;
  logic [31:0] nm3;
  logic [10:0] ex3;
  logic [63:0] dq3;

  logic        dnan;
  logic        tnan;
  logic        gt;
  logic        exc_f;

  assign up_c = (up_r > IDX_MAX) ? IDX_MAX : up_r;
  assign dn_c = (dn_r > IDX_MAX) ? IDX_MAX : dn_r;

  assign out_load      = ~out_valid_r | out_word.ready;
  assign en            = out_load | ~add_valid;
  assign in_word.ready = en;
  assign cfg_word.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_r  <= '0;
      dn_r  <= '0;
      thr_r <= '0;
    end else if (cfg_word.valid) begin
      case (cfg_word.index)
        REG_POWER_UP:   up_r  <= cfg_word.data[4:0];
        REG_POWER_DOWN: dn_r  <= cfg_word.data[4:0];
        REG_MAX_ERROR:  thr_r <= cfg_word.data;
        default: ;
      endcase
    end
  end

  dfi_fmul u_mul_up (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_word.valid),
    .a(in_word.value_bits), .b(POS_POW[up_c]), .out_valid(m0_valid), .y(m0_y)
  );

  dfi_fmul u_mul_dn (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(m0_valid),
    .a(m0_y), .b(NEG_POW[dn_c]), .out_valid(m1_valid), .y(m1_y)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      va_dly_r[0] <= in_word.value_bits;
      for (int i = 1; i < 2 * FMUL_LAT; i++) begin
        va_dly_r[i] <= va_dly_r[i-1];
      end
    end
  end

  always_comb begin
    pe     = m1_y[62:52];
    big1   = (pe == EXP_MAX) || (pe >= 11'd1055);
    small1 = (pe < 11'd1022);
    sh1    = 6'(pe - 11'd1022);
    f1     = small1 ? 86'd0 : ({33'd0, 1'b1, m1_y[51:0]} << sh1);
  end

  always_comb begin
    ip2   = r1_f_r[85:53];
    up2   = r1_f_r[52] & ((|r1_f_r[51:0]) | ip2[0]);
    mag2  = {1'b0, ip2} + 34'(up2);
    exc2  = r1_big_r | (r1_s_r ? (mag2 > 34'h0_8000_0000) : (mag2 > 34'h0_7FFF_FFFF));
    qmag2 = exc2 ? 32'd0 : mag2[31:0];
  end

  always_comb begin
    lz3 = lzc64({r2_qmag_r, 32'd0});
    nm3 = r2_qmag_r << lz3[4:0];
    ex3 = 11'(11'd1054 - {4'd0, lz3});
    dq3 = (r2_qmag_r == '0) ? 64'd0 : {r2_qneg_r, ex3, nm3[30:0], 21'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_valid_r <= 1'b0;
      r2_valid_r <= 1'b0;
      r3_valid_r <= 1'b0;
    end else if (en) begin
      r1_valid_r <= m1_valid;
      r2_valid_r <= r1_valid_r;
      r3_valid_r <= r2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_s_r    <= m1_y[63];
      r1_big_r  <= big1;
      r1_f_r    <= f1;
      r1_v_r    <= va_dly_r[2*FMUL_LAT-1];

      r2_exc_r  <= exc2;
      r2_qmag_r <= qmag2;
      r2_qneg_r <= r1_s_r & (qmag2 != '0);
      r2_q_r    <= r1_s_r ? (32'd0 - qmag2) : qmag2;
      r2_v_r    <= r1_v_r;

      r3_dq_r   <= dq3;
      r3_q_r    <= r2_q_r;
      r3_exc_r  <= r2_exc_r;
      r3_v_r    <= r2_v_r;
    end
  end

  dfi_fmul u_mul_back_dn (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(r3_valid_r),
    .a(r3_dq_r), .b(POS_POW[dn_c]), .out_valid(m2_valid), .y(m2_y)
  );

  dfi_fmul u_mul_back_up (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(m2_valid),
    .a(m2_y), .b(NEG_POW[up_c]), .out_valid(m3_valid), .y(m3_y)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= '{v: r3_v_r, q: r3_q_r, exc: r3_exc_r};
      for (int i = 1; i < SIDE_LEN; i++) begin
        sd_r[i] <= sd_r[i-1];
      end
    end
  end

  dfi_fadd u_sub (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(m3_valid),
    .x(m3_y), .y(sd_r[2*FMUL_LAT-1].v), .out_valid(add_valid), .z(diff)
  );

  always_comb begin
    dnan  = (diff[62:52] == EXP_MAX) && (diff[51:0] != '0);
    tnan  = (thr_r[62:52] == EXP_MAX) && (thr_r[51:0] != '0);
    if (dnan || tnan) begin
      gt = 1'b0;
    end else if (thr_r[63]) begin
      gt = !((diff[62:0] == '0) && (thr_r[62:0] == '0));
    end else begin
      gt = diff[62:0] > thr_r[62:0];
    end
    exc_f = sd_r[SIDE_LEN-1].exc | gt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= add_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && add_valid) begin
      enc_r <= exc_f ? 32'd0 : sd_r[SIDE_LEN-1].q;
      exc_r <= exc_f;
    end
  end

  assign out_word.valid          = out_valid_r;
  assign out_word.encoded_value  = $signed(enc_r);
  assign out_word.exception_flag = exc_r;

  a_exc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && exc_r |-> enc_r == 32'd0)
    else $error("exception word carries a nonzero value");

  a_qmag_range: assert property (@(posedge clk) disable iff (!rst_n)
    r2_valid_r && !r2_exc_r |-> r2_qmag_r <= 32'h8000_0000)
    else $error("rounded magnitude out of range without exception");

  a_zero_conv: assert property (@(posedge clk) disable iff (!rst_n)
    r3_valid_r && r3_q_r == 32'd0 |-> r3_dq_r == 64'd0)
    else $error("zero integer did not convert to positive zero");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(r3_q_r) && $stable(r2_q_r))
    else $error("rounding stages moved during a stall");

endmodule

FILE: tb/sv/dfi_tb_pkg.sv
// Shared result record and gap picker for the decimal float encoder testbench.
`timescale 1ns / 1ps
package dfi_tb_pkg;

  typedef struct packed {
    logic signed [31:0] encoded_value;
    logic               exception_flag;
  } enc_result_t;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

endpackage

FILE: tb/sv/tb_decimal_float_to_int_encoder.sv
// Testbench for decimal_float_to_int_encoder: directed and random doubles checked against a scaling model.
`timescale 1ns / 1ps
module tb_decimal_float_to_int_encoder;
  import dfi_pkg::*;
  import dfi_tb_pkg::*;

  localparam int SETTLE_CYCLES = 45;

  logic clk;
  logic rst_n;

  dfi_in_if  in_ch();
  dfi_out_if out_ch();
  dfi_cfg_if cfg_ch();

  decimal_float_to_int_encoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_ch.sink),
    .out_word (out_ch.source),
    .cfg_word (cfg_ch.sink)
  );

  logic [4:0]  up_idx;
  logic [4:0]  down_idx;
  logic [63:0] err_limit_bits;

  enc_result_t pending_codes[$];
  int          mismatches;
  int          hold_left;
  int          stall_left;

  always #6 clk = ~clk;

  function automatic int clamp_power(logic [4:0] i);
    int lim;
    lim = DFI_POWER_ENTRIES - 1;
    if (lim > 20) lim = 20;
    return (int'(i) > lim) ? lim : int'(i);
  endfunction

  function automatic enc_result_t encode_value(logic [63:0] bits);
    enc_result_t res;
    int          up;
    int          dn;
    real         v;
    real         p;
    real         frac;
    real         d;
    real         diff;
    longint      q;
    up = clamp_power(up_idx);
    dn = clamp_power(down_idx);
    v  = $bitstoreal(bits);
    p  = v * $bitstoreal(POS_POW[up]) * $bitstoreal(NEG_POW[dn]);
    res.exception_flag = 1'b0;
    q = 0;
    if (p >= -2147483648.5 && p < 2147483647.5) begin
      q    = $rtoi(p);
      frac = p - real'(q);
      if (p >= 0.0) begin
        if (frac > 0.5 || (frac == 0.5 && q[0])) q = q + 1;
      end else begin
        if (frac < -0.5 || (frac == -0.5 && q[0])) q = q - 1;
      end
      if (q < -64'sd2147483648 || q > 64'sd2147483647) begin
        res.exception_flag = 1'b1;
        q = 0;
      end else begin
        d    = real'(q) * $bitstoreal(POS_POW[dn]) * $bitstoreal(NEG_POW[up]);
        diff = d - v;
        if (diff < 0.0) diff = -diff;
        if (diff > $bitstoreal(err_limit_bits)) begin
          res.exception_flag = 1'b1;
          q = 0;
        end
      end
    end else begin
      res.exception_flag = 1'b1;
    end
    res.encoded_value = q[31:0];
    return res;
  endfunction

  task automatic send_word(logic [63:0] bits);
    int g;
    in_ch.valid      <= 1'b1;
    in_ch.value_bits <= bits;
    forever begin
      @(negedge clk);
      if (in_ch.ready) break;
      @(posedge clk);
    end
    pending_codes.push_back(encode_value(bits));
    @(posedge clk);
    g = pick_gap();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    wait (pending_codes.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [63:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    forever begin
      @(negedge clk);
      if (cfg_ch.ready) break;
      @(posedge clk);
    end
    case (idx)
      REG_POWER_UP:   up_idx = data[4:0];
      REG_POWER_DOWN: down_idx = data[4:0];
      default:        err_limit_bits = data;
    endcase
    @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [63:0] up, logic [63:0] dn, real lim);
    write_reg(REG_POWER_UP, up);
    write_reg(REG_POWER_DOWN, dn);
    write_reg(REG_MAX_ERROR, $realtobits(lim));
  endtask

  function automatic logic [63:0] random_value(int max_dec);
    int  m;
    int  e;
    real v;
    if ($urandom_range(0, 99) < 20) return {$urandom, $urandom};
    m = $urandom_range(0, 3) == 0 ? int'($urandom) : $urandom_range(0, 2000000);
    e = $urandom_range(0, max_dec);
    v = real'(m) * $bitstoreal(NEG_POW[e]);
    if ($urandom_range(0, 1)) v = -v;
    return $realtobits(v);
  endfunction

  task automatic run_random(int count, int max_dec);
    for (int i = 0; i < count; i++) send_word(random_value(max_dec));
    drain();
  endtask

  task automatic test_directed_edges();
    logic [63:0] vals[$];
    configure(0, 0, 0.0);
    vals = '{64'h0, 64'h8000_0000_0000_0000, $realtobits(1.0), $realtobits(2.5),
             $realtobits(3.5), $realtobits(-2.5), $realtobits(-3.5), $realtobits(0.5),
             $realtobits(1.5), $realtobits(0.1), $realtobits(2147483647.0),
             $realtobits(2147483647.5), $realtobits(-2147483648.0),
             $realtobits(-2147483648.5), $realtobits(-2147483649.0),
             $realtobits(4294967296.0), 64'h7FF0_0000_0000_0000,
             64'hFFF0_0000_0000_0000, QNAN, 64'h7FEF_FFFF_FFFF_FFFF,
             64'h0000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF};
    foreach (vals[i]) send_word(vals[i]);
    drain();
  endtask

  task automatic test_nan_limit();
    configure(3, 0, 0.0);
    write_reg(REG_MAX_ERROR, QNAN);
    send_word($realtobits(0.12345));
    send_word($realtobits(-7.0001));
    send_word(QNAN);
    drain();
    run_random(150, 8);
  endtask

  task automatic test_cents();
    configure(2, 0, 1.0e-9);
    run_random(200, 3);
  endtask

  task automatic test_saturated_index();
    configure(31, 25, 1.0e-3);
    run_random(150, 4);
    configure(20, 20, 0.0);
    run_random(150, 6);
  endtask

  task automatic test_down_scaling();
    configure(0, 20, 1.0e30);
    write_reg(REG_MAX_ERROR, 64'hFFFF_FFFF_FFFF_FFFF);
    run_random(80, 2);
    configure(0, 3, 500.0);
    run_random(150, 2);
  endtask

  task automatic test_backpressure();
    configure(4, 1, 1.0e-6);
    @(negedge clk);
    hold_left = 300;
    @(posedge clk);
    run_random(150, 4);
  endtask

  task automatic test_wide_random();
    configure(6, 2, 1.0e-7);
    run_random(120, 5);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   = stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left   = pick_gap();
    end
  end

  always @(negedge clk) begin
    enc_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_codes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %0d exc %0b",
                                       out_ch.encoded_value, out_ch.exception_flag);
      end else begin
        want = pending_codes.pop_front();
        if (out_ch.encoded_value !== want.encoded_value ||
            out_ch.exception_flag !== want.exception_flag) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want %0d exc %0b, got %0d exc %0b", want.encoded_value,
                     want.exception_flag, out_ch.encoded_value, out_ch.exception_flag);
        end
      end
    end
  end

  initial begin
    #(12 * 600000);
    $display("tb_decimal_float_to_int_encoder: done, errors");
    $finish;
  end

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.value_bits = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_POWER_UP;
    cfg_ch.data      = '0;
    out_ch.ready     = 1'b0;
    up_idx           = '0;
    down_idx         = '0;
    err_limit_bits   = '0;
    mismatches       = 0;
    hold_left        = 0;
    stall_left       = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_nan_limit();
    test_cents();
    test_saturated_index();
    test_down_scaling();
    test_backpressure();
    test_wide_random();
    if (mismatches == 0 && pending_codes.size() == 0)
      $display("tb_decimal_float_to_int_encoder: done, clean");
    else
      $display("tb_decimal_float_to_int_encoder: done, errors");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/dfi_pkg.sv
hw/rtl/dfi_if.sv
hw/rtl/dfi_fmul.sv
hw/rtl/dfi_fadd.sv
hw/rtl/decimal_float_to_int_encoder.sv
tb/sv/dfi_tb_pkg.sv
tb/sv/tb_decimal_float_to_int_encoder.sv
